@@ src/skvt_pkg.sv @@
package skvt_pkg;

  // operation codes carried in the kind field
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_DUP       = 2'd3;

  localparam int unsigned CFG_BITS   = 7;
  localparam int unsigned KEY_IN_BITS = 32;

  typedef struct packed {
    logic [1:0]             kind;
    logic [KEY_IN_BITS-1:0] key;
    logic [63:0]            value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [63:0]         found_value;
    logic [CFG_BITS-1:0] entry_count;
  } out_item_t;

  // broadcast to every cell in the execute cycle
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

@@ src/skvt_cell.sv @@
module skvt_cell
  import skvt_pkg::*;
#(
  parameter int KW = 32
) (
  input  logic          clk,
  input  cell_cmd_t     cmd,
  input  logic          in_use,
  input  logic [KW-1:0] op_key,
  input  logic [63:0]   op_value,
  input  logic          ext_prev,
  input  logic [KW-1:0] left_key,
  input  logic [63:0]   left_value,
  input  logic [KW-1:0] right_key,
  input  logic [63:0]   right_value,
  output logic          ext,
  output logic          eq,
  output logic [KW-1:0] key_q,
  output logic [63:0]   value_q
);

  logic [KW-1:0] key_r;
  logic [63:0]   value_r;

  // an unused cell counts as holding an infinite key
  assign ext     = !in_use || (key_r >= op_key);
  assign eq      = in_use && (key_r == op_key);
  assign key_q   = key_r;
  assign value_q = value_r;

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (ext_prev) begin
        key_r   <= left_key;
        value_r <= left_value;
      end else if (ext) begin
        key_r   <= op_key;
        value_r <= op_value;
      end
    end else if (cmd.rem && ext) begin
      key_r   <= right_key;
      value_r <= right_value;
    end
  end

endmodule

@@ src/sorted_key_value_table_top.sv @@
// sorted key/value table: a row of cells kept in ascending key order
// an accepted item is captured, then executed once the result register can take it
// no new item is accepted until the captured one has executed
// reset: synchronous active-low rst_n clears the count, the fsm and the output valid;
//   max_entries returns to 64, cell contents are left as they are
module sorted_key_value_table_top
  import skvt_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_wdata
);

  // stored key width: the key port carries 32 bits at most
  localparam int KW = (KEY_BITS < KEY_IN_BITS) ? KEY_BITS : KEY_IN_BITS;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > CFG_BITS) ? CW : CFG_BITS;

  state_t              state_r, state_nxt;
  logic                exec;
  logic [CFG_BITS-1:0] max_entries_r;
  logic [CW-1:0]       count_r, count_nxt;

  // captured operation
  logic [1:0]    op_kind_r;
  logic [KW-1:0] op_key_r;
  logic [63:0]   op_value_r;

  logic      out_valid_r;
  out_item_t out_data_r, out_data_nxt;

  // cell row
  logic [CAPACITY-1:0] in_use, ext, eq;
  logic [KW-1:0]       cell_key   [CAPACITY];
  logic [63:0]         cell_value [CAPACITY];
  cell_cmd_t           cmd;
  logic                hit, full;
  logic [63:0]         hit_value;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // control fsm: capture in idle, execute once the output register is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    exec      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          exec      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // operand capture on an input transfer
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_kind_r  <= in_data.kind;
      op_key_r   <= in_data.key[KW-1:0];
      op_value_r <= in_data.value;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= CFG_BITS'(64);
    end else if (cfg_we) begin
      max_entries_r <= cfg_wdata;
    end
  end

  // cells below the count hold live pairs
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic          ext_prev;
      logic [KW-1:0] left_key, right_key;
      logic [63:0]   left_value, right_value;

      assign in_use[gi] = (CW'(gi) < count_r);

      if (gi == 0) begin : g_first
        assign ext_prev   = 1'b0;
        assign left_key   = op_key_r;
        assign left_value = op_value_r;
      end else begin : g_mid
        assign ext_prev   = ext[gi-1];
        assign left_key   = cell_key[gi-1];
        assign left_value = cell_value[gi-1];
      end

      // the last cell has no right neighbor and keeps its own pair
      if (gi == CAPACITY - 1) begin : g_last
        assign right_key   = cell_key[gi];
        assign right_value = cell_value[gi];
      end else begin : g_inner
        assign right_key   = cell_key[gi+1];
        assign right_value = cell_value[gi+1];
      end

      skvt_cell #(.KW(KW)) u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .in_use      (in_use[gi]),
        .op_key      (op_key_r),
        .op_value    (op_value_r),
        .ext_prev    (ext_prev),
        .left_key    (left_key),
        .left_value  (left_value),
        .right_key   (right_key),
        .right_value (right_value),
        .ext         (ext[gi]),
        .eq          (eq[gi]),
        .key_q       (cell_key[gi]),
        .value_q     (cell_value[gi])
      );
    end
  endgenerate

  // keys are unique, so at most one cell matches
  assign hit = |eq;

  always_comb begin
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_value = hit_value | (eq[i] ? cell_value[i] : 64'd0);
    end
  end

  // limit is max_entries saturated at the capacity
  assign full = (LW'(count_r) >= LW'(max_entries_r)) || (count_r >= CW'(CAPACITY));

  // duplicate check comes before the full check
  always_comb begin
    cmd          = '0;
    count_nxt    = count_r;
    out_data_nxt = '0;
    case (op_kind_r)
      KIND_INSERT: begin
        if (hit) begin
          out_data_nxt.status = STAT_DUP;
        end else if (full) begin
          out_data_nxt.status = STAT_FULL;
        end else begin
          cmd.ins   = exec;
          count_nxt = count_r + CW'(1);
        end
      end
      KIND_LOOKUP: begin
        if (hit) begin
          out_data_nxt.found_value = hit_value;
        end else begin
          out_data_nxt.status = STAT_NOT_FOUND;
        end
      end
      KIND_REMOVE: begin
        if (hit) begin
          cmd.rem   = exec;
          count_nxt = count_r - CW'(1);
        end else begin
          out_data_nxt.status = STAT_NOT_FOUND;
        end
      end
      default: ;
    endcase
    out_data_nxt.entry_count = CFG_BITS'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (exec) begin
      count_r <= count_nxt;
    end
  end

  // result register, freed by an output transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

@@ tb/tb_sorted_key_value_table_top.sv @@
module tb_sorted_key_value_table_top;
  import skvt_pkg::*;

  localparam int TABLE_CAP = 64;
  localparam int POOL_SIZE = 100;
  localparam int PHASES = 9;
  // kind 3 is not an operation, the block must leave the table alone
  localparam logic [1:0] KIND_NONE = 2'd3;
  // windows (in cycles of each side's own counter) where that side does not idle at random
  localparam int TX_CALM_FROM = 1200;
  localparam int TX_CALM_TO = 1800;
  localparam int RX_CALM_FROM = 1000;
  localparam int RX_CALM_TO = 1700;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_BITS-1:0] cfg_wdata = '0;

  // shadow copy of the table, updated in transfer order
  logic [31:0] tbl_keys [TABLE_CAP];
  logic [63:0] tbl_vals [TABLE_CAP];
  int tbl_count = 0;
  int cap_limit = 64;

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  int n_queued = 0;
  int n_accepted = 0;
  int mismatches = 0;
  logic in_fire = 1'b0;

  int tx_cycle = 0;
  int rx_cycle = 0;
  int hold_left = 0;
  bit hold_seen = 1'b0;

  logic [31:0] key_pool [POOL_SIZE];

  sorted_key_value_table_top #(
    .CAPACITY(TABLE_CAP),
    .KEY_BITS(32)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // applies one operation to the shadow table and returns the result it must give
  function automatic out_item_t table_step(in_item_t item);
    out_item_t r;
    int pos;
    int lim;
    bit hit;
    r = '0;
    lim = (cap_limit > TABLE_CAP) ? TABLE_CAP : cap_limit;
    // first slot whose key is not below the new key
    pos = tbl_count;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_keys[i] >= item.key) begin
        pos = i;
        break;
      end
    end
    hit = (pos < tbl_count) && (tbl_keys[pos] == item.key);
    case (item.kind)
      KIND_INSERT: begin
        // duplicate wins over full
        if (hit) begin
          r.status = STAT_DUP;
        end else if (tbl_count >= lim) begin
          r.status = STAT_FULL;
        end else begin
          for (int i = tbl_count; i > pos; i--) begin
            tbl_keys[i] = tbl_keys[i-1];
            tbl_vals[i] = tbl_vals[i-1];
          end
          tbl_keys[pos] = item.key;
          tbl_vals[pos] = item.value;
          tbl_count++;
          r.status = STAT_OK;
        end
      end
      KIND_LOOKUP: begin
        if (hit) begin
          r.status = STAT_OK;
          r.found_value = tbl_vals[pos];
        end else begin
          r.status = STAT_NOT_FOUND;
        end
      end
      KIND_REMOVE: begin
        if (hit) begin
          for (int i = pos; i + 1 < tbl_count; i++) begin
            tbl_keys[i] = tbl_keys[i+1];
            tbl_vals[i] = tbl_vals[i+1];
          end
          tbl_count--;
          r.status = STAT_OK;
        end else begin
          r.status = STAT_NOT_FOUND;
        end
      end
      default: r.status = STAT_OK;
    endcase
    r.entry_count = tbl_count[CFG_BITS-1:0];
    return r;
  endfunction

  task automatic queue_op(input logic [1:0] kind, input logic [31:0] key,
                          input logic [63:0] value);
    in_item_t it;
    it.kind = kind;
    it.key = key;
    it.value = value;
    pending_items.push_back(it);
    n_queued++;
  endtask

  // only called while nothing is in flight
  task automatic write_limit(input logic [CFG_BITS-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cap_limit = v;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (n_accepted != n_queued || expected_results.size() != 0);
  endtask

  // sender: holds a stalled transfer, otherwise offers the next pending item
  // or idles at random
  always @(negedge clk) begin
    tx_cycle++;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      in_valid <= 1'b1;
    end else if (pending_items.size() > 0 &&
                 ((tx_cycle >= TX_CALM_FROM && tx_cycle < TX_CALM_TO) ||
                  $urandom_range(0, 99) >= 21)) begin
      in_data <= pending_items.pop_front();
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: random stalls, one calm stretch, and long hold-offs while the
  // sender still has plenty queued so the block backs up into its input
  always @(negedge clk) begin
    rx_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rst_n && (n_queued - n_accepted) > 40 &&
                 (!hold_seen || $urandom_range(0, 299) == 0)) begin
      hold_left = $urandom_range(40, 80);
      hold_seen = 1'b1;
      out_stall <= 1'b1;
    end else if (rx_cycle >= RX_CALM_FROM && rx_cycle < RX_CALM_TO) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 21);
    end
  end

  // monitor: predicts on every input transfer, checks every result transfer
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        expected_results.push_back(table_step(in_data));
        n_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d found_value=%h entry_count=%0d",
                   $time, out_data.status, out_data.found_value, out_data.entry_count);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status ||
              out_data.found_value !== want.found_value ||
              out_data.entry_count !== want.entry_count) begin
            $display("%0t: expected status=%0d found_value=%h entry_count=%0d",
                     $time, want.status, want.found_value, want.entry_count);
            $display("%0t: actual   status=%0d found_value=%h entry_count=%0d",
                     $time, out_data.status, out_data.found_value, out_data.entry_count);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    logic [CFG_BITS-1:0] limit_plan [PHASES];
    int ins_plan [PHASES];
    int pool_used;
    int n_items;
    int r;
    logic [1:0] kind;
    logic [31:0] key;
    logic [31:0] base;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, key extremes, middle insert, duplicate, misses,
    // the unused kind, and removal from the middle
    queue_op(KIND_LOOKUP, 32'd5, 64'd0);
    queue_op(KIND_REMOVE, 32'd5, '1);
    queue_op(KIND_INSERT, 32'd0, 64'd0);
    queue_op(KIND_INSERT, 32'hFFFF_FFFF, '1);
    queue_op(KIND_INSERT, 32'd1000, {$urandom, $urandom});
    queue_op(KIND_INSERT, 32'd500, 64'h5555_AAAA_5555_AAAA);
    queue_op(KIND_INSERT, 32'd0, 64'h1234);
    queue_op(KIND_LOOKUP, 32'd0, '1);
    queue_op(KIND_LOOKUP, 32'hFFFF_FFFF, 64'd0);
    queue_op(KIND_LOOKUP, 32'd500, 64'd0);
    queue_op(KIND_LOOKUP, 32'd7, 64'd0);
    queue_op(KIND_NONE, 32'hFFFF_FFFF, '1);
    queue_op(KIND_REMOVE, 32'd500, 64'd0);
    queue_op(KIND_REMOVE, 32'd7, 64'd0);
    wait_drained();

    // limit of zero refuses every insert, a duplicate still reports duplicate
    write_limit(7'd0);
    queue_op(KIND_INSERT, 32'd42, 64'd1);
    queue_op(KIND_INSERT, 32'd0, 64'd2);
    queue_op(KIND_LOOKUP, 32'd1000, 64'd0);
    wait_drained();

    // limit below the current count: inserts refused, lookup and remove still work
    write_limit(7'd1);
    queue_op(KIND_INSERT, 32'd43, 64'd3);
    queue_op(KIND_REMOVE, 32'd0, 64'd0);
    queue_op(KIND_LOOKUP, 32'd0, 64'd0);
    wait_drained();

    // above capacity acts as capacity
    write_limit(7'h7F);
    queue_op(KIND_INSERT, 32'd43, 64'd4);

    // random phases; the first one is insert-heavy to fill the table up
    limit_plan = '{7'h7F, 7'd64, 7'd3, 7'd1, 7'($urandom_range(4, 63)), 7'd0,
                   7'($urandom_range(65, 126)), 7'd2, 7'd64};
    ins_plan = '{85, 50, 40, 20, 55, 30, 60, 15, 50};

    // keys clustered around a base so inserts land everywhere in the order,
    // with some fully random keys and the extremes mixed in
    base = $urandom;
    for (int i = 0; i < POOL_SIZE; i++) begin
      r = $urandom_range(0, 15);
      if (r == 0) key_pool[i] = 32'd0;
      else if (r == 1) key_pool[i] = 32'hFFFF_FFFF;
      else if (r < 4) key_pool[i] = $urandom;
      else key_pool[i] = base + $urandom_range(0, 4095);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_limit(limit_plan[p]);
      // refresh part of the pool so later phases also meet new keys
      if (p > 0) begin
        for (int i = 0; i < 20; i++) begin
          key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
        end
      end
      pool_used = (p == 0) ? POOL_SIZE : $urandom_range(6, POOL_SIZE);
      n_items = (p == 0) ? 140 : 95;
      for (int n = 0; n < n_items; n++) begin
        r = $urandom_range(0, 99);
        if (r < 3) kind = KIND_NONE;
        else if (r < 3 + ins_plan[p]) kind = KIND_INSERT;
        else if (r[0]) kind = KIND_LOOKUP;
        else kind = KIND_REMOVE;
        if ($urandom_range(0, 9) == 0) key = $urandom;
        else key = key_pool[$urandom_range(0, pool_used - 1)];
        queue_op(kind, key, {$urandom, $urandom});
      end
    end

    wait_drained();
    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit far beyond the slowest legal run
  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule
